// ===== src/bgd_pkg.sv =====
// ----------------------------------------------------------------------------
// Button gesture detector package
// Shared types and constants for the gesture detector and its checker.
// ----------------------------------------------------------------------------
package bgd_pkg;

   // Timer count width. Each timer also has a separate run bit.
   localparam int TMR_W = 7;
   // Width of the click count and of its saturation limit.
   localparam int CLICK_W = 4;
   // Highest click count. Further short clicks are not counted.
   localparam logic [CLICK_W-1:0] MAX_CLICKS = CLICK_W'(10);

   // Reset values of the two threshold registers.
   localparam logic [TMR_W-1:0] LONG_PRESS_RESET   = TMR_W'(24);
   localparam logic [TMR_W-1:0] CLICK_WINDOW_RESET = TMR_W'(8);

   // Item kinds carried in req_tuser.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_KEY  = 1'b1;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_LONG_PRESS   = 1'b0,
      CSR_CLICK_WINDOW = 1'b1
   } csr_index_type;

   // One input item as the core sees it.
   typedef struct packed {
      logic take_long;
      logic take_clicks;
      logic key_pressed;
      logic op;
   } step_type;

   // One result item; click_count sits in the lowest bits.
   typedef struct packed {
      logic               key_down;
      logic               double_click_and_hold;
      logic               click_and_hold;
      logic               hold_active;
      logic               long_press_event;
      logic [CLICK_W-1:0] click_count;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

// ===== src/button_gesture_detector.sv =====
// ----------------------------------------------------------------------------
// Button gesture detector
// Classifies presses of one key into clicks, long presses and click-and-holds.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless a waiting result stalls it:
// each item is either a timer tick or a key level change, and each gives
// exactly one result item with the gesture state after that step. An
// accepted item sits in an input register, where the gesture core updates
// its state and loads the result register once that register is free or
// draining; the result then appears on the rsp_ side. The input and result
// registers let a new item be taken while the previous result is still
// waiting; the sustained rate is one item per cycle, limited only by how fast
// rsp_tready takes results. The two thresholds must be written through the
// csr_ port only while no item is in flight; the block does not enforce this.
module button_gesture_detector (
   input  logic                      clock,
   input  logic                      reset,
   // Input items.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [0] key_pressed, [1] take_clicks, [2] take_long, [7:3] zero.
   input  logic [7:0]                req_tdata,
   // [0] op: 0 timer tick, 1 key level change.
   input  logic                      req_tuser,
   // Result items.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [3:0] click_count, [4] long_press_event, [5] hold_active,
   // [6] click_and_hold, [7] double_click_and_hold, [8] key_down, [15:9] zero.
   output logic [15:0]               rsp_tdata,
   // Configuration writes: index 0 long_press_ticks, 1 click_window_ticks.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [0:0]                csr_index,
   input  logic [bgd_pkg::TMR_W-1:0] csr_data
);
   import bgd_pkg::*;

   logic             in_valid_ff, in_valid_in;
   step_type         in_step_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff;
   result_type       core_result;
   logic [TMR_W-1:0] long_ticks_ff;
   logic [TMR_W-1:0] window_ticks_ff;
   logic             advance;
   logic             fire;
   logic             req_take;

   // The held item is processed when the result register is free or draining.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         long_ticks_ff   <= LONG_PRESS_RESET;
         window_ticks_ff <= CLICK_WINDOW_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LONG_PRESS:   long_ticks_ff   <= csr_data;
               CSR_CLICK_WINDOW: window_ticks_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_step_ff.op          <= req_tuser;
         in_step_ff.key_pressed <= req_tdata[0];
         in_step_ff.take_clicks <= req_tdata[1];
         in_step_ff.take_long   <= req_tdata[2];
      end
      if (fire) begin
         rsp_data_ff <= core_result;
      end
   end

   bgd_core u_core (
      .clock              (clock),
      .reset              (reset),
      .step_valid         (fire),
      .step               (in_step_ff),
      .long_press_ticks   (long_ticks_ff),
      .click_window_ticks (window_ticks_ff),
      .result             (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(16 - RESULT_W)'(0), rsp_data_ff};

endmodule

// ===== src/bgd_core.sv =====
// ----------------------------------------------------------------------------
// Button gesture core
// Holds the gesture state and computes each step and its result combinationally.
// ----------------------------------------------------------------------------
module bgd_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_valid,
   input  bgd_pkg::step_type         step,
   input  logic [bgd_pkg::TMR_W-1:0] long_press_ticks,
   input  logic [bgd_pkg::TMR_W-1:0] click_window_ticks,
   output bgd_pkg::result_type       result
);
   import bgd_pkg::*;

   logic               key_ff, key_in;
   logic               h_run_ff, h_run_in;
   logic [TMR_W-1:0]   h_cnt_ff, h_cnt_in;
   logic               w_run_ff, w_run_in;
   logic [TMR_W-1:0]   w_cnt_ff, w_cnt_in;
   logic [CLICK_W-1:0] count_ff, count_in;
   logic               ready_ff, ready_in;
   logic               pending_ff, pending_in;
   logic               seen_ff, seen_in;
   logic               single_ff, single_in;
   logic               double_ff, double_in;

   always_comb begin
      key_in     = key_ff;
      h_run_in   = h_run_ff;
      h_cnt_in   = h_cnt_ff;
      w_run_in   = w_run_ff;
      w_cnt_in   = w_cnt_ff;
      count_in   = count_ff;
      ready_in   = ready_ff;
      pending_in = pending_ff;
      seen_in    = seen_ff;
      single_in  = single_ff;
      double_in  = double_ff;
      result     = '0;

      if (step.op == OP_TICK) begin
         // Running timers count up to their threshold and stay there.
         if (h_run_ff && h_cnt_ff < long_press_ticks) begin
            h_cnt_in = h_cnt_ff + TMR_W'(1);
         end
         if (w_run_ff && w_cnt_ff < click_window_ticks) begin
            w_cnt_in = w_cnt_ff + TMR_W'(1);
         end
         // A held key keeps the click window open from its start.
         if (key_in && w_run_in) begin
            w_cnt_in = '0;
         end
         if (key_in && h_run_in && h_cnt_in == long_press_ticks) begin
            if (count_in == CLICK_W'(1) || count_in == CLICK_W'(2)) begin
               w_run_in   = 1'b0;
               w_cnt_in   = '0;
               ready_in   = 1'b0;
               seen_in    = 1'b0;
               pending_in = 1'b0;
               double_in  = (count_in == CLICK_W'(2));
               single_in  = (count_in == CLICK_W'(1));
               count_in   = '0;
            end else begin
               double_in  = 1'b0;
               single_in  = 1'b0;
               pending_in = 1'b1;
               seen_in    = 1'b1;
            end
            h_run_in = 1'b0;
            h_cnt_in = '0;
         end
         if (!key_in && w_run_in && w_cnt_in == click_window_ticks) begin
            w_run_in = 1'b0;
            w_cnt_in = '0;
            if (!seen_in) begin
               ready_in = 1'b1;
            end else begin
               seen_in = 1'b0;
            end
         end
      end else if (step.key_pressed) begin
         key_in = 1'b1;
         if (w_run_ff) begin
            w_cnt_in = '0;
         end
         if (!h_run_ff) begin
            h_run_in = 1'b1;
            h_cnt_in = '0;
         end
      end else begin
         key_in   = 1'b0;
         h_run_in = 1'b0;
         h_cnt_in = '0;
         if (seen_ff || single_ff || double_ff) begin
            // Releasing a hold ends it without counting a click.
            seen_in   = 1'b0;
            single_in = 1'b0;
            double_in = 1'b0;
         end else if (h_cnt_ff < long_press_ticks) begin
            if (count_ff < MAX_CLICKS) begin
               count_in = count_ff + CLICK_W'(1);
            end
            w_run_in = 1'b1;
            w_cnt_in = '0;
         end
      end

      // Report, then apply the take flags.
      if (!seen_in && ready_in) begin
         result.click_count = count_in;
         if (step.take_clicks) begin
            ready_in = 1'b0;
            count_in = '0;
         end
      end
      result.long_press_event = pending_in;
      if (step.take_long) begin
         pending_in = 1'b0;
      end
      result.hold_active           = seen_in;
      result.click_and_hold        = single_in;
      result.double_click_and_hold = double_in;
      result.key_down              = key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= 1'b0;
         h_run_ff   <= 1'b0;
         h_cnt_ff   <= '0;
         w_run_ff   <= 1'b0;
         w_cnt_ff   <= '0;
         count_ff   <= '0;
         ready_ff   <= 1'b0;
         pending_ff <= 1'b0;
         seen_ff    <= 1'b0;
         single_ff  <= 1'b0;
         double_ff  <= 1'b0;
      end else if (step_valid) begin
         key_ff     <= key_in;
         h_run_ff   <= h_run_in;
         h_cnt_ff   <= h_cnt_in;
         w_run_ff   <= w_run_in;
         w_cnt_ff   <= w_cnt_in;
         count_ff   <= count_in;
         ready_ff   <= ready_in;
         pending_ff <= pending_in;
         seen_ff    <= seen_in;
         single_ff  <= single_in;
         double_ff  <= double_in;
      end
   end

endmodule

// ===== src/bgd_checker.sv =====
// ----------------------------------------------------------------------------
// Button gesture detector checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module bgd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [15:0]               rsp_tdata
);
   import bgd_pkg::*;

   result_type res;
   assign res = result_type'(rsp_tdata[RESULT_W-1:0]);

   // At most one kind of hold is reported at a time.
   a_one_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({res.hold_active, res.click_and_hold,
                               res.double_click_and_hold}))
      else $error("more than one hold kind reported");

   // Any hold result implies the key is still down.
   a_hold_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (res.hold_active || res.click_and_hold || res.double_click_and_hold)
      |-> res.key_down)
      else $error("hold reported with key up");

   // A click count is bounded and never shown during a long hold.
   a_clicks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.click_count != '0
      |-> res.click_count <= MAX_CLICKS && !res.hold_active)
      else $error("bad click count");

   // A stalled result holds.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (.*);
